@@ rtl/range_max_2d_sparse_table_macros.svh @@
// Assertion macros used by the checker file.
`ifndef RANGE_MAX_2D_SPARSE_TABLE_MACROS_SVH
`define RANGE_MAX_2D_SPARSE_TABLE_MACROS_SVH
// Assert that a property holds on every clock edge outside reset.
`define RM2_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property that must also hold while reset is applied.
`define RM2_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/rm2st_pkg.sv @@
// Package with the item types and constants of the 2D sparse table block.
`default_nettype none
package rm2st_pkg;
  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int ValueWidth = 32;
  localparam int CfgWidth = 7;
  localparam int CoordWidth = 6;

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpBuild = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  localparam logic KindBuild = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [CoordWidth-1:0] row_first;
    logic [CoordWidth-1:0] col_first;
    logic [CoordWidth-1:0] row_last;
    logic [CoordWidth-1:0] col_last;
    logic signed [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic result_kind;
    logic signed [31:0] max_value;
    logic range_error;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/range_max_2d_sparse_table.sv @@
// Top level: 2D sparse table for rectangle maximum queries over one memory.
// Usage: items enter on in_valid/in_stall, results leave on out_valid/out_stall.
// A load item writes one element and gives no result; while no result waits,
// loads can follow each other on every cycle.
// A query item checks its rectangle, then reads four blocks from the table
// memory, one per cycle, and passes S_QLAST, S_QFIN and S_OUT before out_valid
// rises; the next item is taken once the receiver takes the result.
// A bad query or a build with nothing to fill goes straight to S_OUT.
// A build item sweeps every level: per table entry two reads and one write
// on the table memory; it then gives one done result.
// The block takes one item at a time; in_stall is high while an item is at
// work or its result waits in the output register.
// cfg_we with cfg_index 0 or 1 sets the rows or columns in use (saturated to
// the maximum); write these only while idle.
// Synchronous reset sets both counts to their maximum and empties the output;
// the table memory is not cleared, so load before build and build before query.
// A stalled result holds in the output register until taken.
`default_nettype none
module range_max_2d_sparse_table #(
  parameter int MAX_ROWS = rm2st_pkg::MaxRows,
  parameter int MAX_COLS = rm2st_pkg::MaxCols,
  parameter int VALUE_WIDTH = rm2st_pkg::ValueWidth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire rm2st_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output rm2st_pkg::out_item_t out_data,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [rm2st_pkg::CfgWidth-1:0] cfg_data
);
  localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RLV = $clog2(MAX_ROWS + 1);
  localparam int CLV = $clog2(MAX_COLS + 1);
  localparam int KRB = (RLV > 1) ? $clog2(RLV) : 1;
  localparam int KCB = (CLV > 1) ? $clog2(CLV) : 1;
  localparam int NB = $clog2(MAX_ROWS + 1);
  localparam int MB = $clog2(MAX_COLS + 1);
  localparam int DEPTH = RLV * CLV * MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = rm2st_pkg::CoordWidth;
  localparam int EW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_BRDA  = 8'b00000010,
    S_BRDB  = 8'b00000100,
    S_BWR   = 8'b00001000,
    S_QRD   = 8'b00010000,
    S_QLAST = 8'b00100000,
    S_QFIN  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic rd_en, wr_en;
  logic [VALUE_WIDTH-1:0] wr_data;

  localparam int CfgWidthL = rm2st_pkg::CfgWidth;
  logic [CfgWidthL-1:0] rows_r, cols_r;
  logic [NB-1:0] n_cl;
  logic [MB-1:0] m_cl;

  logic [KRB-1:0] kr_r, kr_nxt, kr_top;
  logic [KCB-1:0] kc_r, kc_nxt, kc_top;
  logic [RB:0] r_r, r_nxt;
  logic [CB:0] c_r, c_nxt;
  logic [VALUE_WIDTH-1:0] a_r, best_r, best_nxt;
  logic [1:0] qi_r, qi_nxt;
  logic [RB-1:0] qr1_r, qrb_r;
  logic [CB-1:0] qc1_r, qcb_r;
  logic [KRB-1:0] qkr_r;
  logic [KCB-1:0] qkc_r;
  rm2st_pkg::out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  function automatic logic [AW-1:0] slot(input logic [KRB-1:0] kr, input logic [KCB-1:0] kc,
                                         input logic [RB-1:0] r, input logic [CB-1:0] c);
    logic [AW+KRB+KCB+RB+CB:0] s;
    s = (((AW+KRB+KCB+RB+CB+1)'(kr) * (AW+KRB+KCB+RB+CB+1)'(CLV)
         + (AW+KRB+KCB+RB+CB+1)'(kc)) * (AW+KRB+KCB+RB+CB+1)'(MAX_ROWS)
         + (AW+KRB+KCB+RB+CB+1)'(r)) * (AW+KRB+KCB+RB+CB+1)'(MAX_COLS)
         + (AW+KRB+KCB+RB+CB+1)'(c);
    return s[AW-1:0];
  endfunction

  function automatic logic [3:0] flog2(input logic [10:0] v);
    logic [3:0] k;
    k = '0;
    for (int i = 1; i < 11; i++) begin
      if (v[i]) k = 4'(i);
    end
    return k;
  endfunction

  function automatic logic sgt(input logic [VALUE_WIDTH-1:0] a, input logic [VALUE_WIDTH-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

  assign n_cl = (32'(rows_r) > 32'(MAX_ROWS)) ? NB'(MAX_ROWS) : NB'(rows_r);
  assign m_cl = (32'(cols_r) > 32'(MAX_COLS)) ? MB'(MAX_COLS) : MB'(cols_r);
  assign kr_top = KRB'(flog2(11'(n_cl)));
  assign kc_top = KCB'(flog2(11'(m_cl)));

  // Table memory: one write port and one read port, reads registered.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CfgWidthL'(MAX_ROWS > 64 ? 64 : MAX_ROWS);
      cols_r <= CfgWidthL'(MAX_COLS > 64 ? 64 : MAX_COLS);
    end else if (cfg_we) begin
      if (cfg_index == rm2st_pkg::CfgRows) rows_r <= cfg_data;
      else cols_r <= cfg_data;
    end
  end

  // Sizes of the current build level.
  logic [RB+1:0] hk;
  logic [CB+1:0] wk;
  logic [RB:0] r_off;
  logic [CB:0] c_off;
  logic kr_src;
  always_comb begin
    hk = (RB+2)'(1) << kr_r;
    wk = (CB+2)'(1) << kc_r;
    kr_src = (kr_r != '0);
    r_off = kr_src ? (RB+1)'(hk >> 1) : '0;
    c_off = kr_src ? '0 : (CB+1)'(wk >> 1);
  end

  logic in_acc;
  logic q_bad;
  logic [CW:0] qh, qw;
  logic [3:0] qkr, qkc;
  logic [CW:0] qrb, qcb;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  always_comb begin
    qh = (CW+1)'(in_data.row_last) - (CW+1)'(in_data.row_first) + 1'b1;
    qw = (CW+1)'(in_data.col_last) - (CW+1)'(in_data.col_first) + 1'b1;
    qkr = flog2(11'(qh));
    qkc = flog2(11'(qw));
    qrb = (CW+1)'(in_data.row_last) + 1'b1 - ((CW+1)'(1) << qkr);
    qcb = (CW+1)'(in_data.col_last) + 1'b1 - ((CW+1)'(1) << qkc);
    q_bad = (in_data.row_first > in_data.row_last) || (in_data.col_first > in_data.col_last)
         || (32'(in_data.row_last) >= 32'(n_cl)) || (32'(in_data.col_last) >= 32'(m_cl));
  end

  logic last_c, last_r, last_kc, last_kr;
  always_comb begin
    state_nxt = state_r;
    kr_nxt = kr_r; kc_nxt = kc_r; r_nxt = r_r; c_nxt = c_r;
    qi_nxt = qi_r; best_nxt = best_r;
    out_nxt = out_r; out_valid_nxt = out_valid_r;
    rd_en = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    last_c = (32'(c_r) + 32'(wk) + 1 > 32'(m_cl));
    last_r = (32'(r_r) + 32'(hk) + 1 > 32'(n_cl));
    last_kc = (kc_r == kc_top);
    last_kr = (kr_r == kr_top);
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.operation)
            rm2st_pkg::OpLoad: begin
              if (32'(in_data.row_first) < MAX_ROWS && 32'(in_data.col_first) < MAX_COLS) begin
                wr_en = 1'b1;
                wr_addr = slot('0, '0, RB'(in_data.row_first), CB'(in_data.col_first));
                wr_data = VALUE_WIDTH'($signed(in_data.element_value[EW-1:0]));
              end
            end
            rm2st_pkg::OpBuild: begin
              out_nxt = '{result_kind: rm2st_pkg::KindBuild, max_value: '0, range_error: 1'b0};
              if (n_cl == '0 || m_cl == '0 || (kr_top == '0 && kc_top == '0)) begin
                state_nxt = S_OUT;
              end else begin
                kr_nxt = '0; kc_nxt = KCB'(1); r_nxt = '0; c_nxt = '0;
                if (kc_top == '0) begin kr_nxt = KRB'(1); kc_nxt = '0; end
                state_nxt = S_BRDA;
              end
            end
            rm2st_pkg::OpQuery: begin
              if (q_bad) begin
                out_nxt = '{result_kind: rm2st_pkg::KindQuery, max_value: '0,
                            range_error: 1'b1};
                state_nxt = S_OUT;
              end else begin
                qi_nxt = '0;
                state_nxt = S_QRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_BRDA: begin
        rd_en = 1'b1;
        rd_addr = kr_src ? slot(kr_r - 1'b1, kc_r, RB'(r_r), CB'(c_r))
                         : slot(kr_r, kc_r - 1'b1, RB'(r_r), CB'(c_r));
        state_nxt = S_BRDB;
      end
      S_BRDB: begin
        rd_en = 1'b1;
        rd_addr = kr_src ? slot(kr_r - 1'b1, kc_r, RB'(r_r + r_off), CB'(c_r))
                         : slot(kr_r, kc_r - 1'b1, RB'(r_r), CB'(c_r + c_off));
        state_nxt = S_BWR;
      end
      S_BWR: begin
        wr_en = 1'b1;
        wr_addr = slot(kr_r, kc_r, RB'(r_r), CB'(c_r));
        wr_data = sgt(rd_data_r, a_r) ? rd_data_r : a_r;
        state_nxt = S_BRDA;
        if (!last_c) c_nxt = c_r + 1'b1;
        else begin
          c_nxt = '0;
          if (!last_r) r_nxt = r_r + 1'b1;
          else begin
            r_nxt = '0;
            if (!last_kc) kc_nxt = kc_r + 1'b1;
            else if (!last_kr) begin kc_nxt = '0; kr_nxt = kr_r + 1'b1; end
            else state_nxt = S_OUT;
          end
        end
      end
      S_QRD: begin
        rd_en = 1'b1;
        case (qi_r)
          2'd0: rd_addr = slot(qkr_r, qkc_r, qr1_r, qc1_r);
          2'd1: rd_addr = slot(qkr_r, qkc_r, qr1_r, qcb_r);
          2'd2: rd_addr = slot(qkr_r, qkc_r, qrb_r, qc1_r);
          default: rd_addr = slot(qkr_r, qkc_r, qrb_r, qcb_r);
        endcase
        if (qi_r == 2'd1) best_nxt = rd_data_r;
        else if (qi_r != 2'd0 && sgt(rd_data_r, best_r)) best_nxt = rd_data_r;
        qi_nxt = qi_r + 1'b1;
        if (qi_r == 2'd3) state_nxt = S_QLAST;
      end
      S_QLAST: begin
        if (sgt(rd_data_r, best_r)) best_nxt = rd_data_r;
        state_nxt = S_QFIN;
      end
      S_QFIN: begin
        out_nxt = '{result_kind: rm2st_pkg::KindQuery,
                    max_value: 32'($signed(best_r)), range_error: 1'b0};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kr_r <= kr_nxt; kc_r <= kc_nxt; r_r <= r_nxt; c_r <= c_nxt;
    qi_r <= qi_nxt; best_r <= best_nxt; out_r <= out_nxt;
    if (state_r == S_BRDB) a_r <= rd_data_r;
    if (in_acc) begin
      qr1_r <= RB'(in_data.row_first);
      qc1_r <= CB'(in_data.col_first);
      qrb_r <= RB'(qrb);
      qcb_r <= CB'(qcb);
      qkr_r <= KRB'(qkr);
      qkc_r <= KCB'(qkc);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule
`default_nettype wire

@@ rtl/rm2st_checker.sv @@
// Port checker for the 2D sparse table block, bound to its top level.
`default_nettype none
`include "range_max_2d_sparse_table_macros.svh"
module rm2st_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire rm2st_pkg::out_item_t out_data
);
  `RM2_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `RM2_ASSERT(a_busy_out, clk, rst_n, out_valid |-> in_stall, "item accepted while result waits")
  `RM2_ASSERT(a_acc_quiet, clk, rst_n, in_valid && !in_stall |=> !out_valid, "result too soon after an accepted item")
  `RM2_ASSERT(a_build_clean, clk, rst_n, out_valid && out_data.result_kind == rm2st_pkg::KindBuild |-> out_data.max_value == 0 && !out_data.range_error, "build result not zero")
  `RM2_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result after reset")
endmodule

bind range_max_2d_sparse_table rm2st_checker u_rm2st_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
